[hdl/lsfd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lsfd_pkg: shared types, constants and helpers of the lidar frame decoder
// Holds the frame patterns, the CORDIC angle table, rounding helpers and the
// sequencer state type.
// ----------------------------------------------------------------------------
package lsfd_pkg;

    localparam int PAYLOAD_BYTES = 1080;
    localparam int BEAMS         = 361;
    localparam int HEADER_BYTES  = 20;
    localparam int START_BYTES   = 6;
    localparam int WIN_LEN       = (HEADER_BYTES > START_BYTES) ? HEADER_BYTES : START_BYTES;

    localparam int CW          = 36;   // CORDIC datapath width
    localparam int CORDIC_LAST = 30;   // 31 micro-rotations
    localparam int SQRT_LAST   = 31;   // 32 root digits

    typedef logic signed [CW-1:0] t_cval;

    localparam logic [31:0] PI_Q30      = 32'd3373259426;
    localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
    localparam logic [31:0] CORDIC_K    = 32'd652032874;
    localparam logic [31:0] ANG_STEP_Q  = 32'(PI_Q30 / 360);
    localparam logic [8:0]  ANG_STEP_R  = 9'(PI_Q30 % 360);
    localparam logic [8:0]  ANG_DIV     = 9'd360;

    localparam logic [12:0] RANGE_LIMIT_RESET = 13'd7500;
    localparam logic signed [15:0] BEARING_MAX = 16'sd25736;

    // Configuration register indexes.
    localparam logic [1:0] CFG_OFFSET_X = 2'd0;
    localparam logic [1:0] CFG_OFFSET_Y = 2'd1;
    localparam logic [1:0] CFG_RANGE    = 2'd2;

    typedef enum logic [1:0] {
        EV_START = 2'd0,
        EV_POINT = 2'd1,
        EV_DONE  = 2'd2
    } t_event;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TRIG,
        ST_MULX,
        ST_MULY,
        ST_SQX,
        ST_SQY,
        ST_SQRT_GO,
        ST_SQRT,
        ST_VEC,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic start;
        logic rotate;
    } t_cordic_cmd;

    typedef struct packed {
        logic hdr;
        logic start;
    } t_match;

    localparam logic [7:0] HDR_PAT [HEADER_BYTES] = '{
        8'h73, 8'h53, 8'h4e, 8'h20, 8'h4c, 8'h4d, 8'h44, 8'h73, 8'h63, 8'h61,
        8'h6e, 8'h64, 8'h61, 8'h74, 8'h61, 8'h20, 8'h31, 8'h20, 8'h45, 8'h42
    };

    localparam logic [7:0] START_PAT [START_BYTES] = '{
        8'h06, 8'h02, 8'h80, 8'h03, 8'h00, 8'hA0
    };

    function automatic t_cval atan_q30(input logic [4:0] k);
        t_cval a;
        case (k)
            5'd0:  a = 36'sd843314857;
            5'd1:  a = 36'sd497837829;
            5'd2:  a = 36'sd263043837;
            5'd3:  a = 36'sd133525159;
            5'd4:  a = 36'sd67021687;
            5'd5:  a = 36'sd33543516;
            5'd6:  a = 36'sd16775851;
            5'd7:  a = 36'sd8388437;
            5'd8:  a = 36'sd4194283;
            5'd9:  a = 36'sd2097149;
            default: a = t_cval'(36'd1 << (5'd30 - k));
        endcase
        return a;
    endfunction

    // Round a Q2.30 value to Q1.15 and clamp to 16 bits.
    function automatic logic signed [15:0] round_q15(input t_cval v);
        logic signed [CW:0] s;
        logic signed [CW:0] t;
        logic signed [15:0] r;
        s = {v[CW-1], v} + 37'sd16384;
        t = s >>> 15;
        if (t > 37'sd32767) begin
            r = 16'sh7FFF;
        end else if (t < -37'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = t[15:0];
        end
        return r;
    endfunction

    // Round a Q2.30 angle to Q3.13 and clamp to the bearing range.
    function automatic logic signed [15:0] round_q13(input t_cval v);
        logic signed [CW:0] s;
        logic signed [CW:0] t;
        logic signed [15:0] r;
        s = {v[CW-1], v} + 37'sd65536;
        t = s >>> 17;
        if (t > 37'sd25736) begin
            r = BEARING_MAX;
        end else if (t < -37'sd25736) begin
            r = -BEARING_MAX;
        end else begin
            r = t[15:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[hdl/lsfd_match.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lsfd_match: byte window and pattern matcher
// Shifts each byte into a window of the newest bytes and flags a scan header
// or a start reply; a hit clears the window.
// ----------------------------------------------------------------------------
module lsfd_match (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_shift,
    input  wire logic [7:0]       i_byte,
    output lsfd_pkg::t_match      o_match
);

    logic [7:0] r_win [lsfd_pkg::WIN_LEN];
    logic [7:0] n_win [lsfd_pkg::WIN_LEN];

    always_comb begin
        for (int i = 0; i < lsfd_pkg::WIN_LEN - 1; i++) begin
            n_win[i] = r_win[i + 1];
        end
        n_win[lsfd_pkg::WIN_LEN - 1] = i_byte;

        o_match.hdr = 1'b1;
        for (int i = 0; i < lsfd_pkg::HEADER_BYTES; i++) begin
            if (n_win[lsfd_pkg::WIN_LEN - lsfd_pkg::HEADER_BYTES + i] != lsfd_pkg::HDR_PAT[i]) begin
                o_match.hdr = 1'b0;
            end
        end

        o_match.start = 1'b1;
        for (int i = 0; i < lsfd_pkg::START_BYTES; i++) begin
            if (n_win[lsfd_pkg::WIN_LEN - lsfd_pkg::START_BYTES + i] != lsfd_pkg::START_PAT[i]) begin
                o_match.start = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < lsfd_pkg::WIN_LEN; i++) begin
                r_win[i] <= 8'd0;
            end
        end else if (i_shift) begin
            for (int i = 0; i < lsfd_pkg::WIN_LEN; i++) begin
                r_win[i] <= (o_match.hdr || o_match.start) ? 8'd0 : n_win[i];
            end
        end
    end

endmodule
`default_nettype wire

[hdl/lsfd_cordic.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lsfd_cordic: iterative CORDIC unit, rotation and vectoring modes
// One micro-rotation per cycle; o_done pulses after the last one.
// ----------------------------------------------------------------------------
module lsfd_cordic (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire lsfd_pkg::t_cordic_cmd i_cmd,
    input  wire lsfd_pkg::t_cval      i_x,
    input  wire lsfd_pkg::t_cval      i_y,
    input  wire lsfd_pkg::t_cval      i_z,
    output logic                      o_done,
    output lsfd_pkg::t_cval           o_x,
    output lsfd_pkg::t_cval           o_y,
    output lsfd_pkg::t_cval           o_z
);

    logic            r_run;
    logic            r_done;
    logic            r_rot;
    logic [4:0]      r_k;
    lsfd_pkg::t_cval r_x, r_y, r_z;
    lsfd_pkg::t_cval n_x, n_y, n_z;
    lsfd_pkg::t_cval dx, dy, at;
    logic            sigma;

    always_comb begin
        dx    = r_y >>> r_k;
        dy    = r_x >>> r_k;
        at    = lsfd_pkg::atan_q30(r_k);
        // Rotation drives z toward zero, vectoring drives y toward zero.
        sigma = r_rot ? ~r_z[lsfd_pkg::CW-1] : r_y[lsfd_pkg::CW-1];
        n_x   = sigma ? r_x - dx : r_x + dx;
        n_y   = sigma ? r_y + dy : r_y - dy;
        n_z   = sigma ? r_z - at : r_z + at;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_run <= 1'b1;
            end else if (r_run && r_k == 5'(lsfd_pkg::CORDIC_LAST)) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_x   <= i_x;
            r_y   <= i_y;
            r_z   <= i_z;
            r_rot <= i_cmd.rotate;
            r_k   <= 5'd0;
        end else if (r_run) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
            r_k <= r_k + 5'd1;
        end
    end

    assign o_done = r_done;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;

endmodule
`default_nettype wire

[hdl/lsfd_isqrt.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lsfd_isqrt: digit-by-digit integer square root of a 64-bit value
// One root bit per cycle; o_done pulses with the floor root.
// ----------------------------------------------------------------------------
module lsfd_isqrt (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_value,
    output logic             o_done,
    output logic [31:0]      o_root
);

    logic        r_run;
    logic        r_done;
    logic [4:0]  r_j;
    logic [63:0] r_v;
    logic [63:0] r_r;
    logic [63:0] bit_w;
    logic [64:0] trial;
    logic        ge;

    always_comb begin
        bit_w = 64'd1 << {r_j, 1'b0};
        trial = {1'b0, r_r} + {1'b0, bit_w};
        ge    = {1'b0, r_v} >= trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run && r_j == 5'd0) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v <= i_value;
            r_r <= 64'd0;
            r_j <= 5'(lsfd_pkg::SQRT_LAST);
        end else if (r_run) begin
            if (ge) begin
                r_v <= r_v - trial[63:0];
                r_r <= (r_r >> 1) + bit_w;
            end else begin
                r_r <= r_r >> 1;
            end
            r_j <= r_j - 5'd1;
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[31:0];

endmodule
`default_nettype wire

[hdl/lidar_scan_frame_decoder_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lidar_scan_frame_decoder_unit: lidar link byte decoder with point conversion
// Timing: start and done events are registered and leave the cycle after their
//   byte; a point leaves after two 31-step CORDIC runs, the multiplier states
//   MULX, MULY, SQX and SQY and a 32-step square root; a point at the origin skips the second run.
// Throughput: one byte per cycle while the output is free, except that a byte
//   which yields a point holds the input until that point has been emitted.
// Reset: synchronous, active low; clears window, scan state and configuration.
// ----------------------------------------------------------------------------
module lidar_scan_frame_decoder_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write port.
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [14:0] i_cfg_data,
    // Input beats: one received byte each.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    // Output beats: one event each.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,   // [8:0] beam_index, [23:9] radius_cm,
                                             // [39:24] bearing, [48:40] points_in_scan
    output logic [1:0]       m_axis_tuser    // [1:0] event_kind
);

    // Configuration registers.
    logic signed [14:0] r_off_x;
    logic signed [14:0] r_off_y;
    logic [12:0]        r_limit;

    // Control state.
    lsfd_pkg::t_state r_state, n_state;
    logic             r_in_payload, n_in_payload;
    logic [10:0]      r_pay_cnt, n_pay_cnt;
    logic [8:0]       r_point_cnt, n_point_cnt;
    logic             r_out_valid;

    // Datapath registers (no reset needed).
    logic [7:0]         r_held, n_held;
    logic [31:0]        r_ang_q, n_ang_q;
    logic [8:0]         r_ang_r, n_ang_r;
    logic [12:0]        r_dist, n_dist;
    logic [8:0]         r_beam, n_beam;
    logic               r_neg, n_neg;
    logic signed [15:0] r_sq, n_sq;
    logic signed [15:0] r_cq, n_cq;
    logic signed [31:0] r_x, n_x;
    logic signed [31:0] r_y, n_y;
    logic [63:0]        r_v, n_v;
    logic [14:0]        r_rad, n_rad;
    logic signed [15:0] r_bear, n_bear;

    // Output register.
    lsfd_pkg::t_event   r_out_kind;
    logic [8:0]         r_out_beam;
    logic [14:0]        r_out_rad;
    logic signed [15:0] r_out_bear;
    logic [8:0]         r_out_pts;

    logic               out_load;
    lsfd_pkg::t_event   out_kind;
    logic [8:0]         out_beam;
    logic [14:0]        out_rad;
    logic signed [15:0] out_bear;
    logic [8:0]         out_pts;

    // Shared unit connections.
    lsfd_pkg::t_cordic_cmd cordic_cmd;
    lsfd_pkg::t_cval       cordic_x_in, cordic_y_in, cordic_z_in;
    lsfd_pkg::t_cval       cordic_x, cordic_y, cordic_z;
    logic                  cordic_done;
    logic                  sqrt_start;
    logic                  sqrt_done;
    logic [31:0]           sqrt_root;
    lsfd_pkg::t_match      match;

    logic               in_accept;
    logic               out_free;
    logic [10:0]        idx;
    logic               last_byte;
    logic               in_beams;
    logic [12:0]        pair_dist;
    logic [8:0]         ang_r_sum;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] product;
    lsfd_pkg::t_cval    trig_x, trig_y;
    lsfd_pkg::t_cval    ang_c;
    logic [32:0]        rad_sum;
    logic [31:0]        off_x_q15, off_y_q15;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == lsfd_pkg::ST_IDLE) && out_free;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign idx       = r_pay_cnt;
    assign last_byte = (idx == 11'(lsfd_pkg::PAYLOAD_BYTES - 1));
    assign in_beams  = (idx < 11'(2 * lsfd_pkg::BEAMS));
    // Distance is the held low byte plus the low five bits of the high byte.
    assign pair_dist = {s_axis_tdata[4:0], r_held};
    assign ang_r_sum = r_ang_r + lsfd_pkg::ANG_STEP_R;
    assign ang_c     = lsfd_pkg::t_cval'({4'd0, r_ang_q});
    assign off_x_q15 = {{2{r_off_x[14]}}, r_off_x, 15'd0};
    assign off_y_q15 = {{2{r_off_y[14]}}, r_off_y, 15'd0};

    // Window and pattern matcher; only bytes outside a payload enter it.
    lsfd_match u_match (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (in_accept && !r_in_payload),
        .i_byte  (s_axis_tdata),
        .o_match (match)
    );

    // One CORDIC unit serves both the beam sin/cos and the bearing.
    lsfd_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cordic_cmd),
        .i_x     (cordic_x_in),
        .i_y     (cordic_y_in),
        .i_z     (cordic_z_in),
        .o_done  (cordic_done),
        .o_x     (cordic_x),
        .o_y     (cordic_y),
        .o_z     (cordic_z)
    );

    lsfd_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_value (r_v),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    // The single multiplier: distance times sin and cos, then the two squares.
    always_comb begin
        case (r_state)
            lsfd_pkg::ST_MULX: begin
                mul_a = {19'd0, r_dist};
                mul_b = 32'(r_sq);
            end
            lsfd_pkg::ST_MULY: begin
                mul_a = {19'd0, r_dist};
                mul_b = 32'(r_cq);
            end
            lsfd_pkg::ST_SQX: begin
                mul_a = r_x;
                mul_b = r_x;
            end
            default: begin
                mul_a = r_y;
                mul_b = r_y;
            end
        endcase
        product = mul_a * mul_b;
    end

    // Angles past a right angle were reduced by pi, so the outputs flip sign.
    assign trig_x  = r_neg ? -cordic_x : cordic_x;
    assign trig_y  = r_neg ? -cordic_y : cordic_y;
    assign rad_sum = {1'b0, sqrt_root} + 33'd16384;

    // Sequencer: next state, shared unit commands and output loading.
    always_comb begin
        n_state      = r_state;
        n_in_payload = r_in_payload;
        n_pay_cnt    = r_pay_cnt;
        n_point_cnt  = r_point_cnt;
        n_held       = r_held;
        n_ang_q      = r_ang_q;
        n_ang_r      = r_ang_r;
        n_dist       = r_dist;
        n_beam       = r_beam;
        n_neg        = r_neg;
        n_sq         = r_sq;
        n_cq         = r_cq;
        n_x          = r_x;
        n_y          = r_y;
        n_v          = r_v;
        n_rad        = r_rad;
        n_bear       = r_bear;

        cordic_cmd   = '0;
        cordic_x_in  = lsfd_pkg::t_cval'({4'd0, lsfd_pkg::CORDIC_K});
        cordic_y_in  = '0;
        cordic_z_in  = ang_c;
        sqrt_start   = 1'b0;

        out_load = 1'b0;
        out_kind = lsfd_pkg::EV_START;
        out_beam = 9'd0;
        out_rad  = 15'd0;
        out_bear = 16'sd0;
        out_pts  = 9'd0;

        case (r_state)
            lsfd_pkg::ST_IDLE: begin
                if (in_accept) begin
                    if (r_in_payload) begin
                        if (in_beams && !last_byte) begin
                            if (!idx[0]) begin
                                n_held = s_axis_tdata;
                            end else begin
                                // Step the beam angle by pi/360 in Q2.30,
                                // keeping the exact remainder of the division.
                                if (ang_r_sum >= lsfd_pkg::ANG_DIV) begin
                                    n_ang_r = ang_r_sum - lsfd_pkg::ANG_DIV;
                                    n_ang_q = r_ang_q + lsfd_pkg::ANG_STEP_Q + 32'd1;
                                end else begin
                                    n_ang_r = ang_r_sum;
                                    n_ang_q = r_ang_q + lsfd_pkg::ANG_STEP_Q;
                                end
                                if (pair_dist < r_limit) begin
                                    n_dist            = pair_dist;
                                    n_beam            = idx[9:1];
                                    n_point_cnt       = r_point_cnt + 9'd1;
                                    cordic_cmd.start  = 1'b1;
                                    cordic_cmd.rotate = 1'b1;
                                    if (r_ang_q > lsfd_pkg::HALF_PI_Q30) begin
                                        cordic_z_in = ang_c - lsfd_pkg::t_cval'(
                                            {4'd0, lsfd_pkg::PI_Q30});
                                        n_neg = 1'b1;
                                    end else begin
                                        n_neg = 1'b0;
                                    end
                                    n_state = lsfd_pkg::ST_TRIG;
                                end
                            end
                        end
                        if (last_byte) begin
                            // The last payload byte closes the scan, even if it
                            // would complete a beam.
                            n_in_payload = 1'b0;
                            n_pay_cnt    = 11'd0;
                            out_load     = 1'b1;
                            out_kind     = lsfd_pkg::EV_DONE;
                            out_pts      = r_point_cnt;
                        end else begin
                            n_pay_cnt = idx + 11'd1;
                        end
                    end else if (match.hdr) begin
                        // A header wins over a start reply on the same byte.
                        n_in_payload = 1'b1;
                        n_pay_cnt    = 11'd0;
                        n_point_cnt  = 9'd0;
                        n_ang_q      = 32'd0;
                        n_ang_r      = 9'd0;
                    end else if (match.start) begin
                        out_load = 1'b1;
                        out_kind = lsfd_pkg::EV_START;
                    end
                end
            end

            lsfd_pkg::ST_TRIG: begin
                if (cordic_done) begin
                    n_sq    = lsfd_pkg::round_q15(trig_y);
                    n_cq    = lsfd_pkg::round_q15(trig_x);
                    n_state = lsfd_pkg::ST_MULX;
                end
            end

            lsfd_pkg::ST_MULX: begin
                n_x     = product[31:0] + off_x_q15;
                n_state = lsfd_pkg::ST_MULY;
            end

            lsfd_pkg::ST_MULY: begin
                n_y     = off_y_q15 - product[31:0];
                n_state = lsfd_pkg::ST_SQX;
            end

            lsfd_pkg::ST_SQX: begin
                n_v     = product;
                n_state = lsfd_pkg::ST_SQY;
            end

            lsfd_pkg::ST_SQY: begin
                n_v     = r_v + product;
                n_state = lsfd_pkg::ST_SQRT_GO;
            end

            lsfd_pkg::ST_SQRT_GO: begin
                sqrt_start = 1'b1;
                n_state    = lsfd_pkg::ST_SQRT;
            end

            lsfd_pkg::ST_SQRT: begin
                if (sqrt_done) begin
                    n_rad = (rad_sum[32:15] > 18'd32767) ? 15'h7FFF : rad_sum[29:15];
                    if (r_x == 32'sd0 && r_y == 32'sd0) begin
                        // A point at the origin has bearing zero.
                        n_bear  = 16'sd0;
                        n_state = lsfd_pkg::ST_EMIT;
                    end else begin
                        cordic_cmd.start  = 1'b1;
                        cordic_cmd.rotate = 1'b0;
                        if (r_x < 32'sd0) begin
                            // Fold the left half plane over by pi.
                            cordic_x_in = -lsfd_pkg::t_cval'(r_x);
                            cordic_y_in = -lsfd_pkg::t_cval'(r_y);
                            cordic_z_in = (r_y >= 32'sd0)
                                ? lsfd_pkg::t_cval'({4'd0, lsfd_pkg::PI_Q30})
                                : -lsfd_pkg::t_cval'({4'd0, lsfd_pkg::PI_Q30});
                        end else begin
                            cordic_x_in = lsfd_pkg::t_cval'(r_x);
                            cordic_y_in = lsfd_pkg::t_cval'(r_y);
                            cordic_z_in = '0;
                        end
                        n_state = lsfd_pkg::ST_VEC;
                    end
                end
            end

            lsfd_pkg::ST_VEC: begin
                if (cordic_done) begin
                    n_bear  = lsfd_pkg::round_q13(cordic_z);
                    n_state = lsfd_pkg::ST_EMIT;
                end
            end

            lsfd_pkg::ST_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_kind = lsfd_pkg::EV_POINT;
                    out_beam = r_beam;
                    out_rad  = r_rad;
                    out_bear = r_bear;
                    n_state  = lsfd_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = lsfd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= lsfd_pkg::ST_IDLE;
            r_in_payload <= 1'b0;
            r_pay_cnt    <= 11'd0;
            r_point_cnt  <= 9'd0;
            r_held       <= 8'd0;
            r_out_valid  <= 1'b0;
            r_off_x      <= 15'sd0;
            r_off_y      <= 15'sd0;
            r_limit      <= lsfd_pkg::RANGE_LIMIT_RESET;
        end else begin
            r_state      <= n_state;
            r_in_payload <= n_in_payload;
            r_pay_cnt    <= n_pay_cnt;
            r_point_cnt  <= n_point_cnt;
            r_held       <= n_held;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    lsfd_pkg::CFG_OFFSET_X: r_off_x <= i_cfg_data;
                    lsfd_pkg::CFG_OFFSET_Y: r_off_y <= i_cfg_data;
                    lsfd_pkg::CFG_RANGE:    r_limit <= i_cfg_data[12:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ang_q <= n_ang_q;
        r_ang_r <= n_ang_r;
        r_dist  <= n_dist;
        r_beam  <= n_beam;
        r_neg   <= n_neg;
        r_sq    <= n_sq;
        r_cq    <= n_cq;
        r_x     <= n_x;
        r_y     <= n_y;
        r_v     <= n_v;
        r_rad   <= n_rad;
        r_bear  <= n_bear;
        if (out_load) begin
            r_out_kind <= out_kind;
            r_out_beam <= out_beam;
            r_out_rad  <= out_rad;
            r_out_bear <= out_bear;
            r_out_pts  <= out_pts;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tdata  = {7'd0, r_out_pts, r_out_bear, r_out_rad, r_out_beam};

endmodule
`default_nettype wire
